// File: rtl/lsom_pkg.sv
// Shared constants, codes and types of the layer stack order manager.
package lsom_pkg;

    // Layer count and the span of layer ids that exist for the block
    localparam int MAX_LAYERS = 256;
    localparam int LAYER_SPAN = (MAX_LAYERS < 256) ? MAX_LAYERS : 256;

    // Field widths
    localparam int ID_W  = 8;
    localparam int LVL_W = 9;
    localparam int REQ_W = 10;

    // Scan tree grouping: cells are reduced in groups, then across groups
    localparam int GRP_W = 4;
    localparam int GRP   = 1 << GRP_W;
    localparam int NGRP  = (LAYER_SPAN + GRP - 1) / GRP;

    // Result status codes
    localparam logic STAT_DONE    = 1'b0;
    localparam logic STAT_NO_FREE = 1'b1;

    // Operation codes
    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_SET   = 2'd1,
        OP_FREE  = 2'd2
    } t_op;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESOLVE,
        ST_EXEC
    } t_state;

    // Control broadcast to every cell of the row
    typedef struct packed {
        logic [ID_W-1:0]  tgt_id;
        logic [LVL_W-1:0] shown;
        logic             shift_up;
        logic             shift_dn;
        logic [LVL_W-1:0] lo;
        logic [LVL_W-1:0] hi;
        logic             wr_en;
        logic [LVL_W-1:0] wr_lvl;
        logic             use_set;
        logic             use_clr;
        logic [ID_W-1:0]  use_id;
    } t_cell_ctl;

    // Reduced view of the row for one transaction
    typedef struct packed {
        logic            found;
        logic [ID_W-1:0] old_idx;
        logic            in_use;
        logic            any_free;
        logic [ID_W-1:0] free_idx;
    } t_scan_res;

endpackage

// File: rtl/layer_stack_order_manager.sv
// Top level of the layer stack order manager: sequencer, cell row and scan tree.
//
// Each transaction (allocate, set stacking level, free) is taken when start is high
// and busy is low. Its single result is shown on the o_ ports with o_done high for
// exactly one cycle. The receiver cannot stall it. busy stays high in the scan,
// resolve and update states, so a new transaction may be started in the cycle the
// result is shown, and not before. A transaction passes the two registered stages
// of the scan tree that locate the layer's current level and the lowest free layer,
// an update cycle in which the cells of the moved range shift from their neighbors
// at once, and the cycle in which the result is shown. No clearing pass is needed
// after reset.
module layer_stack_order_manager
    import lsom_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_operation,
    input  logic [ID_W-1:0]         i_layer_id,
    input  logic signed [REQ_W-1:0] i_requested_level,
    output logic                    o_done,
    output logic                    o_status,
    output logic [ID_W-1:0]         o_result_layer,
    output logic signed [LVL_W-1:0] o_result_level,
    output logic [LVL_W-1:0]        o_shown_count
);

    t_state                  r_state;
    t_state                  n_state;
    logic                    w_exec;
    logic [1:0]              r_op;
    logic [ID_W-1:0]         r_id;
    logic signed [REQ_W-1:0] r_req;
    logic signed [LVL_W-1:0] r_top;
    logic signed [LVL_W-1:0] n_top;
    logic                    r_done;
    logic                    r_status;
    logic [ID_W-1:0]         r_layer;
    logic signed [LVL_W-1:0] r_level;
    logic [LVL_W-1:0]        r_count;
    logic                    n_status;
    logic [ID_W-1:0]         n_layer;
    logic signed [LVL_W-1:0] n_level;

    t_cell_ctl               w_ctl;
    t_scan_res               w_scan;
    logic [ID_W-1:0]         w_slot [LAYER_SPAN];
    logic [ID_W-1:0]         w_prev [LAYER_SPAN];
    logic [ID_W-1:0]         w_next [LAYER_SPAN];
    logic [LAYER_SPAN-1:0]   w_lvl_hit;
    logic [LAYER_SPAN-1:0]   w_use_hit;
    logic [LAYER_SPAN-1:0]   w_free;

    logic                    w_is_alloc;
    logic                    w_is_set;
    logic                    w_is_free;
    logic                    w_id_ok;
    logic                    w_act;
    logic signed [LVL_W-1:0] w_old;
    logic signed [REQ_W-1:0] w_old10;
    logic signed [REQ_W-1:0] w_top10;
    logic signed [REQ_W-1:0] w_hi10;
    logic signed [REQ_W-1:0] w_req_c;
    logic signed [REQ_W-1:0] w_req_e;
    logic                    w_lower;
    logic                    w_raise;

    // Sequencer: next state and busy
    always_comb begin
        n_state = r_state;
        busy    = 1'b1;
        w_exec  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_state = ST_RESOLVE;
            end
            ST_RESOLVE: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                w_exec  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the transaction while it is worked on
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_op  <= i_operation;
            r_id  <= i_layer_id;
            r_req <= i_requested_level;
        end
    end

    // Decode the operation
    always_comb begin
        w_is_alloc = 1'b0;
        w_is_set   = 1'b0;
        w_is_free  = 1'b0;
        case (r_op)
            OP_ALLOC: w_is_alloc = 1'b1;
            OP_SET:   w_is_set   = 1'b1;
            OP_FREE:  w_is_free  = 1'b1;
            default: begin
                w_is_alloc = 1'b0;
            end
        endcase
    end

    // Clamp the request and plan the move
    always_comb begin
        w_id_ok = ({1'b0, r_id} < LVL_W'(LAYER_SPAN));
        w_old   = w_scan.found ? $signed({1'b0, w_scan.old_idx}) : -9'sd1;
        w_old10 = $signed({w_old[LVL_W-1], w_old});
        w_top10 = $signed({r_top[LVL_W-1], r_top});
        w_hi10  = (w_old >= 0) ? w_top10 : (w_top10 + 10'sd1);
        w_req_c = (r_req > w_hi10) ? w_hi10 : r_req;
        if (w_req_c < -10'sd1) begin
            w_req_c = -10'sd1;
        end
        w_req_e = w_is_free ? -10'sd1 : w_req_c;
        w_act   = w_id_ok && ((w_is_set && w_scan.in_use) || w_is_free);
        w_lower = w_act && (w_old10 > w_req_e);
        w_raise = w_act && (w_old10 < w_req_e);
    end

    // Build the row control, the new top level and the result
    always_comb begin
        w_ctl          = '0;
        w_ctl.tgt_id   = r_id;
        w_ctl.shown    = $unsigned(r_top + 9'sd1);
        w_ctl.wr_lvl   = w_req_e[LVL_W-1:0];
        w_ctl.use_id   = r_id;
        n_top          = r_top;

        // Lower or remove
        if (w_lower) begin
            if (w_req_e >= 0) begin
                w_ctl.shift_up = 1'b1;
                w_ctl.lo       = w_req_e[LVL_W-1:0];
                w_ctl.hi       = w_old;
                w_ctl.wr_en    = 1'b1;
            end else begin
                w_ctl.shift_dn = 1'b1;
                w_ctl.lo       = w_old;
                w_ctl.hi       = r_top;
                n_top          = r_top - 9'sd1;
            end
        end

        // Raise or insert
        if (w_raise) begin
            w_ctl.wr_en = 1'b1;
            if (w_old >= 0) begin
                w_ctl.shift_dn = 1'b1;
                w_ctl.lo       = w_old;
                w_ctl.hi       = w_req_e[LVL_W-1:0];
            end else begin
                w_ctl.shift_up = 1'b1;
                w_ctl.lo       = w_req_e[LVL_W-1:0];
                w_ctl.hi       = $unsigned(r_top + 9'sd1);
                n_top          = r_top + 9'sd1;
            end
        end

        // Claim the lowest free layer, or release the addressed one
        if (w_is_alloc && w_scan.any_free) begin
            w_ctl.use_set = 1'b1;
            w_ctl.use_id  = w_scan.free_idx;
        end
        if (w_is_free && w_id_ok) begin
            w_ctl.use_clr = 1'b1;
        end

        // Drop every change outside the update cycle
        if (!w_exec) begin
            w_ctl.shift_up = 1'b0;
            w_ctl.shift_dn = 1'b0;
            w_ctl.wr_en    = 1'b0;
            w_ctl.use_set  = 1'b0;
            w_ctl.use_clr  = 1'b0;
            n_top          = r_top;
        end

        n_status = STAT_DONE;
        n_layer  = r_id;
        n_level  = -9'sd1;
        if (w_is_alloc) begin
            n_status = w_scan.any_free ? STAT_DONE : STAT_NO_FREE;
            n_layer  = w_scan.any_free ? w_scan.free_idx : '0;
        end
        if (w_is_set && w_id_ok && w_scan.in_use) begin
            n_level = w_req_e[LVL_W-1:0];
        end
    end

    // Top level and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= -9'sd1;
            r_done <= 1'b0;
        end else begin
            r_top  <= n_top;
            r_done <= w_exec;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status <= n_status;
            r_layer  <= n_layer;
            r_level  <= n_level;
            r_count  <= $unsigned(n_top + 9'sd1);
        end
    end

    // Row of cells, each shifting from its neighbors
    for (genvar k = 0; k < LAYER_SPAN; k++) begin : g_cell
        if (k == 0) begin : g_first
            assign w_prev[k] = '0;
        end else begin : g_inner_prev
            assign w_prev[k] = w_slot[k-1];
        end
        if (k == LAYER_SPAN - 1) begin : g_last
            assign w_next[k] = '0;
        end else begin : g_inner_next
            assign w_next[k] = w_slot[k+1];
        end

        lsom_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_cell_idx (LVL_W'(k)),
            .i_prev_id  (w_prev[k]),
            .i_next_id  (w_next[k]),
            .o_slot_id  (w_slot[k]),
            .o_lvl_hit  (w_lvl_hit[k]),
            .o_use_hit  (w_use_hit[k]),
            .o_free     (w_free[k])
        );
    end

    lsom_scan u_scan (
        .i_clk     (i_clk),
        .i_lvl_hit (w_lvl_hit),
        .i_use_hit (w_use_hit),
        .i_free    (w_free),
        .o_res     (w_scan)
    );

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_result_layer = r_layer;
    assign o_result_level = r_level;
    assign o_shown_count  = r_count;

`ifndef SYNTH
    // A result only follows the update cycle
    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == ST_EXEC))
        else $error("result strobe without an update cycle");

    // An accepted transaction always yields its result strobe
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_done)
        else $error("result missing four cycles after start");

    // Reported shown count matches the stored top level
    a_count_matches_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_shown_count == $unsigned(r_top + 9'sd1)))
        else $error("shown count disagrees with top level");
`endif

endmodule

// File: rtl/lsom_cell.sv
// One cell of the row: the layer id at one stacking level and the in-use flag of one layer.
module lsom_cell
    import lsom_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  logic [LVL_W-1:0] i_cell_idx,
    input  logic [ID_W-1:0]  i_prev_id,
    input  logic [ID_W-1:0]  i_next_id,
    output logic [ID_W-1:0]  o_slot_id,
    output logic             o_lvl_hit,
    output logic             o_use_hit,
    output logic             o_free
);

    logic [ID_W-1:0] r_slot;
    logic [ID_W-1:0] n_slot;
    logic            r_in_use;
    logic            n_in_use;
    logic            w_use_sel;

    assign w_use_sel = (i_cell_idx == {1'b0, i_ctl.use_id});

    // Shift from a neighbor inside the moved range, then place the moved layer
    always_comb begin
        n_slot = r_slot;
        if (i_ctl.shift_up && (i_cell_idx > i_ctl.lo) && (i_cell_idx <= i_ctl.hi)) begin
            n_slot = i_prev_id;
        end
        if (i_ctl.shift_dn && (i_cell_idx >= i_ctl.lo) && (i_cell_idx < i_ctl.hi)) begin
            n_slot = i_next_id;
        end
        if (i_ctl.wr_en && (i_cell_idx == i_ctl.wr_lvl)) begin
            n_slot = i_ctl.tgt_id;
        end
    end

    // Claim or release this cell's layer
    always_comb begin
        n_in_use = r_in_use;
        if (i_ctl.use_set && w_use_sel) begin
            n_in_use = 1'b1;
        end
        if (i_ctl.use_clr && w_use_sel) begin
            n_in_use = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= 1'b0;
        end else begin
            r_in_use <= n_in_use;
        end
    end

    assign o_slot_id = r_slot;
    assign o_lvl_hit = (r_slot == i_ctl.tgt_id) && (i_cell_idx < i_ctl.shown);
    assign o_use_hit = r_in_use && (i_cell_idx == {1'b0, i_ctl.tgt_id});
    assign o_free    = !r_in_use;

endmodule

// File: rtl/lsom_scan.sv
// Two-stage registered reduction of the cell row: level of the target, its in-use flag, lowest free layer.
module lsom_scan
    import lsom_pkg::*;
(
    input  logic                  i_clk,
    input  logic [LAYER_SPAN-1:0] i_lvl_hit,
    input  logic [LAYER_SPAN-1:0] i_use_hit,
    input  logic [LAYER_SPAN-1:0] i_free,
    output t_scan_res             o_res
);

    logic             n_ghit  [NGRP];
    logic [GRP_W-1:0] n_gidx  [NGRP];
    logic             n_guse  [NGRP];
    logic             n_gfree [NGRP];
    logic [GRP_W-1:0] n_gfidx [NGRP];
    logic             r_ghit  [NGRP];
    logic [GRP_W-1:0] r_gidx  [NGRP];
    logic             r_guse  [NGRP];
    logic             r_gfree [NGRP];
    logic [GRP_W-1:0] r_gfidx [NGRP];
    t_scan_res        n_res;
    t_scan_res        r_res;

    // Reduce each group of cells; the level hit is one-hot, the free pick is lowest-first
    always_comb begin
        int k;
        for (int g = 0; g < NGRP; g++) begin
            n_ghit[g]  = 1'b0;
            n_gidx[g]  = '0;
            n_guse[g]  = 1'b0;
            n_gfree[g] = 1'b0;
            n_gfidx[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                k = g * GRP + j;
                if (k < LAYER_SPAN) begin
                    if (i_lvl_hit[k]) begin
                        n_ghit[g] = 1'b1;
                        n_gidx[g] = n_gidx[g] | GRP_W'(j);
                    end
                    if (i_use_hit[k]) begin
                        n_guse[g] = 1'b1;
                    end
                    if (i_free[k]) begin
                        n_gfree[g] = 1'b1;
                        n_gfidx[g] = GRP_W'(j);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGRP; g++) begin
            r_ghit[g]  <= n_ghit[g];
            r_gidx[g]  <= n_gidx[g];
            r_guse[g]  <= n_guse[g];
            r_gfree[g] <= n_gfree[g];
            r_gfidx[g] <= n_gfidx[g];
        end
    end

    // Combine the groups
    always_comb begin
        n_res = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_ghit[g]) begin
                n_res.found   = 1'b1;
                n_res.old_idx = n_res.old_idx | {(ID_W - GRP_W)'(g), r_gidx[g]};
            end
            if (r_guse[g]) begin
                n_res.in_use = 1'b1;
            end
            if (r_gfree[g]) begin
                n_res.any_free = 1'b1;
                n_res.free_idx = {(ID_W - GRP_W)'(g), r_gfidx[g]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// File: tb/layer_stack_order_manager_test.sv
// Self-checking testbench for the layer stack order manager.
`timescale 1ns / 1ps

module layer_stack_order_manager_test
    import lsom_pkg::*;
();

    // Opcode outside the supported set; the block must echo and change nothing
    localparam logic [1:0] OP_UNKNOWN = 2'd3;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    // One result as the block reports it
    typedef struct {
        logic                    status;
        logic [ID_W-1:0]         layer;
        logic signed [LVL_W-1:0] level;
        logic [LVL_W-1:0]        shown;
    } t_outcome;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_operation;
    logic [ID_W-1:0]         i_layer_id;
    logic signed [REQ_W-1:0] i_requested_level;
    logic                    o_done;
    logic                    o_status;
    logic [ID_W-1:0]         o_result_layer;
    logic signed [LVL_W-1:0] o_result_level;
    logic [LVL_W-1:0]        o_shown_count;

    // Predicted stack state
    bit              layer_taken[LAYER_SPAN];
    int              layer_depth[LAYER_SPAN];
    bit [ID_W-1:0]   stack_by_level[LAYER_SPAN];
    int              top_depth;

    // Expected results, oldest first
    t_outcome pending_results[$];

    int mismatches = 0;
    int results_seen = 0;
    int items_sent = 0;
    int op_count[4] = '{0, 0, 0, 0};
    int alloc_refused = 0;
    int deepest_shown = 0;
    int quiet_cycles = 0;
    bit burst_mode = 1'b0;

    layer_stack_order_manager u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_layer_id        (i_layer_id),
        .i_requested_level (i_requested_level),
        .o_done            (o_done),
        .o_status          (o_status),
        .o_result_layer    (o_result_layer),
        .o_result_level    (o_result_level),
        .o_shown_count     (o_shown_count)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Put a layer at a level of the stack
    function automatic void seat(int lvl, int id);
        stack_by_level[lvl] = id[ID_W-1:0];
        layer_depth[id] = lvl;
    endfunction

    // Move a layer to a clamped level, shifting the layers in between
    function automatic void restack(int id, int want);
        int was, ceiling, k;
        was = layer_depth[id];
        ceiling = (was >= 0) ? top_depth : top_depth + 1;
        if (want > ceiling) want = ceiling;
        if (want < -1) want = -1;
        if (was > want) begin
            if (want >= 0) begin
                for (k = was; k > want; k--) seat(k, stack_by_level[k-1]);
                seat(want, id);
            end else begin
                for (k = was; k < top_depth; k++) seat(k, stack_by_level[k+1]);
                layer_depth[id] = -1;
                top_depth--;
            end
        end else if (was < want) begin
            if (was >= 0) begin
                for (k = was; k < want; k++) seat(k, stack_by_level[k+1]);
                seat(want, id);
            end else begin
                for (k = top_depth; k >= want; k--) seat(k + 1, stack_by_level[k]);
                seat(want, id);
                top_depth++;
            end
        end
    endfunction

    // Apply one transaction to the predicted state and return its result
    function automatic t_outcome stack_outcome(logic [1:0] op, logic [ID_W-1:0] id, int want);
        t_outcome r;
        int lvl, k, shown;
        bit found;
        r.status = STAT_DONE;
        r.layer = id;
        lvl = -1;
        found = 1'b0;
        case (op)
            OP_ALLOC: begin
                r.layer = '0;
                r.status = STAT_NO_FREE;
                for (k = 0; k < LAYER_SPAN; k++) begin
                    if (!found && !layer_taken[k]) begin
                        found = 1'b1;
                        layer_taken[k] = 1'b1;
                        layer_depth[k] = -1;
                        r.layer = k[ID_W-1:0];
                        r.status = STAT_DONE;
                    end
                end
            end
            OP_SET: begin
                if (layer_taken[id]) restack(id, want);
                lvl = layer_depth[id];
            end
            OP_FREE: begin
                if (layer_depth[id] >= 0) restack(id, -1);
                layer_taken[id] = 1'b0;
                lvl = layer_depth[id];
            end
            default: ;
        endcase
        shown = top_depth + 1;
        r.level = lvl[LVL_W-1:0];
        r.shown = shown[LVL_W-1:0];
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none in burst stretches
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Drive one transaction, wait for it to be taken, predict it, then idle for the picked gap, if any
    task automatic send_op(logic [1:0] op, logic [ID_W-1:0] id, int want);
        t_outcome r;
        int gap;
        @(negedge i_clk);
        i_operation <= op;
        i_layer_id <= id;
        i_requested_level <= want[REQ_W-1:0];
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        r = stack_outcome(op, id, want);
        pending_results.push_back(r);
        items_sent++;
        op_count[op]++;
        if (r.status == STAT_NO_FREE) alloc_refused++;
        if (top_depth + 1 > deepest_shown) deepest_shown = top_depth + 1;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Hold off new work until every expected result has come back
    task automatic settle();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Pick a layer, usually one that is in use
    function automatic logic [ID_W-1:0] pick_layer();
        int base, k, id;
        id = $urandom_range(0, LAYER_SPAN - 1);
        if ($urandom_range(0, 99) < 85) begin
            base = id;
            for (k = 0; k < LAYER_SPAN; k++) begin
                if (layer_taken[(base + k) % LAYER_SPAN] && id == base)
                    id = (base + k) % LAYER_SPAN;
            end
        end
        return id[ID_W-1:0];
    endfunction

    // Level request: mostly inside the legal range, some hides, some anywhere
    function automatic int pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(0, top_depth + 2) - 1;
        if (r < 85) return -1;
        return $urandom_range(0, 1023) - 512;
    endfunction

    // Edge cases on a small stack: empty stack, clamps, every shift direction
    task automatic test_directed();
        send_op(OP_SET, 8'd5, 0);
        send_op(OP_FREE, 8'd7, 3);
        send_op(OP_UNKNOWN, 8'd255, -512);
        send_op(OP_ALLOC, 8'd200, 0);
        send_op(OP_ALLOC, 8'd0, 0);
        send_op(OP_ALLOC, 8'd255, 0);
        send_op(OP_SET, 8'd0, 511);
        send_op(OP_SET, 8'd1, 0);
        send_op(OP_SET, 8'd2, -512);
        send_op(OP_SET, 8'd2, 1);
        send_op(OP_SET, 8'd1, 511);
        send_op(OP_SET, 8'd1, -1);
        send_op(OP_SET, 8'd0, 0);
        send_op(OP_SET, 8'd0, 0);
        send_op(OP_FREE, 8'd2, 0);
        send_op(OP_ALLOC, 8'd0, 0);
        send_op(OP_UNKNOWN, 8'd0, 511);
        send_op(OP_FREE, 8'd0, 0);
        send_op(OP_FREE, 8'd1, 0);
        send_op(OP_FREE, 8'd2, 0);
        settle();
    endtask

    // Fill every layer, refuse one more, show them all, reshuffle, free them all
    task automatic test_full_stack();
        int k, base;
        for (k = 0; k <= LAYER_SPAN; k++) begin
            send_op(OP_ALLOC, ID_W'($urandom_range(0, 255)), 0);
        end
        for (k = 0; k < LAYER_SPAN; k++) begin
            send_op(OP_SET, k[ID_W-1:0], $urandom_range(0, top_depth + 1));
        end
        send_op(OP_SET, stack_by_level[top_depth], 0);
        send_op(OP_SET, stack_by_level[0], 511);
        send_op(OP_SET, 8'd255, -512);
        send_op(OP_SET, 8'd255, 511);
        settle();
        base = $urandom_range(0, LAYER_SPAN - 1);
        for (k = 0; k < LAYER_SPAN; k++) begin
            send_op(OP_FREE, ID_W'((base + k) % LAYER_SPAN),
                    $urandom_range(0, 1023) - 512);
        end
        settle();
    endtask

    // Random mix in phases that grow, churn and drain the stack
    task automatic test_random();
        int alloc_w[5] = '{50, 20, 10, 35, 5};
        int set_w[5]   = '{45, 70, 60, 50, 35};
        int phase, n, r;
        logic [1:0] op;
        for (phase = 0; phase < 5; phase++) begin
            burst_mode = (phase == 1);
            for (n = 0; n < 100; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) op = OP_UNKNOWN;
                else if (r < 4 + alloc_w[phase]) op = OP_ALLOC;
                else if (r < 4 + alloc_w[phase] + set_w[phase]) op = OP_SET;
                else op = OP_FREE;
                send_op(op, pick_layer(), pick_level());
            end
            if (phase == 2) settle();
        end
        burst_mode = 1'b0;
    endtask

    // Check each result against the oldest expectation; watch for a stall
    always @(posedge i_clk) begin
        t_outcome exp;
        if (i_rst_n && ((start && !busy) || o_done)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
            $display("layer_stack_order_manager verification failed");
            $finish;
        end
        if (i_rst_n && o_done) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with none expected: status %0d layer %0d",
                         $time, o_status, o_result_layer);
                $display("%0t: unexpected result level %0d shown %0d",
                         $time, o_result_level, o_shown_count);
            end else begin
                exp = pending_results.pop_front();
                if (o_status !== exp.status) begin
                    mismatches++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp.status, o_status);
                end
                if (o_result_layer !== exp.layer) begin
                    mismatches++;
                    $display("%0t: result_layer expected %0d actual %0d",
                             $time, exp.layer, o_result_layer);
                end
                if (o_result_level !== exp.level) begin
                    mismatches++;
                    $display("%0t: result_level expected %0d actual %0d",
                             $time, exp.level, o_result_level);
                end
                if (o_shown_count !== exp.shown) begin
                    mismatches++;
                    $display("%0t: shown_count expected %0d actual %0d",
                             $time, exp.shown, o_shown_count);
                end
            end
        end
    end

    initial begin
        int k;
        for (k = 0; k < LAYER_SPAN; k++) begin
            layer_taken[k] = 1'b0;
            layer_depth[k] = -1;
            stack_by_level[k] = '0;
        end
        top_depth = -1;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = OP_ALLOC;
        i_layer_id = '0;
        i_requested_level = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_full_stack();
        test_random();

        settle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d transactions: %0d allocate, %0d set level, %0d free, %0d unknown",
                 items_sent, op_count[OP_ALLOC], op_count[OP_SET], op_count[OP_FREE],
                 op_count[OP_UNKNOWN]);
        $display("%0d results checked; allocate refused %0d times; deepest stack %0d; %0d mismatches",
                 results_seen, alloc_refused, deepest_shown, mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("layer_stack_order_manager verification clean");
        end else begin
            $display("layer_stack_order_manager verification failed");
        end
        $finish;
    end

endmodule
